[rtl/iit_pkg.sv]
package iit_pkg;

  // Product magnitude ceiling, 2^60
  localparam logic [63:0] MAG_LIM = 64'h1000_0000_0000_0000;
  localparam logic signed [63:0] GRAD_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] GRAD_MIN = -64'sh0000_8000_0000_0000;

  typedef enum logic [2:0] {
    REG_SCHEME    = 3'd0,
    REG_STATIC    = 3'd1,
    REG_STEP_TIME = 3'd2,
    REG_INV_STEP  = 3'd3,
    REG_ALPHA     = 3'd4,
    REG_GRAV_X    = 3'd5,
    REG_GRAV_Y    = 3'd6,
    REG_GRAV_Z    = 3'd7
  } cfg_reg_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_MUL  = 6'b000100,
    S_FIN  = 6'b001000,
    S_ACC  = 6'b010000,
    S_OUTP = 6'b100000
  } state_t;

  // Sequencer steps, one shared multiplication each
  typedef enum logic [4:0] {
    ST_MG    = 5'd0,
    ST_MQ    = 5'd1,
    ST_MQG   = 5'd2,
    ST_VEL   = 5'd3,
    ST_ACCEL = 5'd4,
    ST_AM    = 5'd5,
    ST_MA    = 5'd6,
    ST_AMV   = 5'd7,
    ST_MI    = 5'd8,
    ST_MII   = 5'd9,
    ST_AMI   = 5'd10,
    ST_MAA   = 5'd11,
    ST_DT2   = 5'd12,
    ST_KE    = 5'd13,
    ST_ADT   = 5'd14,
    ST_MV    = 5'd15,
    ST_MVV   = 5'd16,
    ST_DE    = 5'd17
  } step_t;

endpackage

[rtl/iit_if.sv]
interface iit_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] prev_position;
  logic signed [31:0] prev_velocity;
  logic        [30:0] mass;
  logic signed [31:0] internal_gradient;
  logic signed [31:0] prev_internal_gradient;
  logic signed [31:0] internal_energy;
  logic               last_element;
  modport source (output valid, position, prev_position, prev_velocity, mass,
                  internal_gradient, prev_internal_gradient, internal_energy,
                  last_element, input ready);
  modport sink (input valid, position, prev_position, prev_velocity, mass,
                internal_gradient, prev_internal_gradient, internal_energy,
                last_element, output ready);
endinterface

interface iit_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] total_gradient;
  logic        [46:0] inertial_hessian_diag;
  logic signed [63:0] total_energy;
  logic               run_end;
  modport source (output valid, total_gradient, inertial_hessian_diag, total_energy,
                  run_end, input ready);
  modport sink (input valid, total_gradient, inertial_hessian_diag, total_energy,
                run_end, output ready);
endinterface

interface iit_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/implicit_integrator_inertia_terms_top.sv]
// Inertial terms of an implicit integrator (backward Euler or Crank-Nicolson) in signed
// fixed point with FRAC_BITS fraction bits. One transaction per degree of freedom; each
// yields one result with the saturated total gradient and inertial Hessian diagonal, and
// the last element of a run also carries the total energy. All products go through one
// 32x32 multiplier: every fixed-point product takes a load step, forms and sums its four
// partial products in the multiply state, and ends in a finish step. An item takes 18
// products when dynamic and 3 products in static mode, plus the entry, summation and
// output load steps. The input is not ready while an item is in work; a finished result
// waits in the output register while the next transaction is taken, and a result still
// waiting there holds the following item in its output step.
module implicit_integrator_inertia_terms_top #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned DIMENSIONS = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  iit_in_if.sink     in_ch,
  iit_out_if.source  out_ch,
  iit_cfg_if.sink    cfg_ch
);

  // configuration
  logic               scheme_r, static_r;
  logic        [30:0] dt_r, inv_r, alpha_r;
  logic signed [31:0] gx_r, gy_r, gz_r;

  // item
  logic signed [31:0] q_r, qp_r, vp_r, gi_r, gpi_r, ei_r, g_r;
  logic        [30:0] m_r;
  logic               last_r;

  iit_pkg::state_t state_r;
  iit_pkg::step_t  step_r;
  logic [1:0]      axis_r;
  logic [2:0]      cnt_r;
  logic [1:0]      sel_d_r;

  logic signed [63:0] grad_r, energy_r, hess_r, v_r, a_r, am_r, ma_r, tmp_r, tmp2_r;
  logic signed [63:0] acc_e_r;
  logic        [63:0] mag_a_r, mag_b_r;
  logic               neg_r;
  logic        [63:0] pp_r;
  logic       [127:0] prod_r;

  logic               out_valid_r;
  logic signed [47:0] out_grad_r;
  logic        [46:0] out_hess_r;
  logic signed [63:0] out_energy_r;
  logic               out_end_r;

  logic in_fire, out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == iit_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.total_gradient        = out_grad_r;
  assign out_ch.inertial_hessian_diag = out_hess_r;
  assign out_ch.total_energy          = out_energy_r;
  assign out_ch.run_end               = out_end_r;

  // sign- or zero-extended item fields
  logic signed [63:0] m_x, q_x, vp_x, g_x, dt_x, inv_x, alpha_x, d_x;
  assign m_x     = {33'd0, m_r};
  assign q_x     = {{32{q_r[31]}}, q_r};
  assign vp_x    = {{32{vp_r[31]}}, vp_r};
  assign g_x     = {{32{g_r[31]}}, g_r};
  assign dt_x    = {33'd0, dt_r};
  assign inv_x   = {33'd0, inv_r};
  assign alpha_x = {33'd0, alpha_r};
  assign d_x     = q_x - {{32{qp_r[31]}}, qp_r};

  // operand selection
  logic signed [63:0] op_a, op_b;
  always_comb begin
    op_a = m_x;
    op_b = inv_x;
    unique case (step_r)
      iit_pkg::ST_MG:    begin op_a = m_x;     op_b = g_x;    end
      iit_pkg::ST_MQ:    begin op_a = m_x;     op_b = q_x;    end
      iit_pkg::ST_MQG:   begin op_a = tmp_r;   op_b = g_x;    end
      iit_pkg::ST_VEL:   begin op_a = scheme_r ? (d_x <<< 1) : d_x; op_b = inv_x; end
      iit_pkg::ST_ACCEL: begin op_a = v_r - vp_x; op_b = inv_x; end
      iit_pkg::ST_AM:    begin op_a = alpha_x; op_b = m_x;    end
      iit_pkg::ST_MA:    begin op_a = m_x;     op_b = a_r;    end
      iit_pkg::ST_AMV:   begin op_a = am_r;    op_b = v_r;    end
      iit_pkg::ST_MI:    begin op_a = m_x;     op_b = inv_x;  end
      iit_pkg::ST_MII:   begin op_a = tmp_r;   op_b = inv_x;  end
      iit_pkg::ST_AMI:   begin op_a = am_r;    op_b = inv_x;  end
      iit_pkg::ST_MAA:   begin op_a = ma_r;    op_b = a_r;    end
      iit_pkg::ST_DT2:   begin op_a = dt_x;    op_b = dt_x;   end
      iit_pkg::ST_KE:    begin op_a = tmp_r;   op_b = tmp2_r; end
      iit_pkg::ST_ADT:   begin op_a = alpha_x; op_b = dt_x;   end
      iit_pkg::ST_MV:    begin op_a = m_x;     op_b = v_r;    end
      iit_pkg::ST_MVV:   begin op_a = tmp2_r;  op_b = v_r;    end
      iit_pkg::ST_DE:    begin op_a = tmp_r;   op_b = tmp2_r; end
      default:           begin op_a = m_x;     op_b = inv_x;  end
    endcase
  end

  // partial product of the current limb pair
  logic [31:0] limb_a, limb_b;
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    begin limb_a = mag_a_r[31:0];  limb_b = mag_b_r[31:0];  end
      2'd1:    begin limb_a = mag_a_r[31:0];  limb_b = mag_b_r[63:32]; end
      2'd2:    begin limb_a = mag_a_r[63:32]; limb_b = mag_b_r[31:0];  end
      default: begin limb_a = mag_a_r[63:32]; limb_b = mag_b_r[63:32]; end
    endcase
  end

  logic [127:0] pp_shift;
  always_comb begin
    case (sel_d_r)
      2'd0:    pp_shift = {64'd0, pp_r};
      2'd1,
      2'd2:    pp_shift = {32'd0, pp_r, 32'd0};
      default: pp_shift = {pp_r, 64'd0};
    endcase
  end

  // rescale, clamp and sign the finished product
  logic        [63:0] p_mag;
  logic signed [63:0] res;
  always_comb begin
    p_mag = prod_r[63:0] >> FRAC_BITS;
    if (prod_r[127:64] != 64'd0 || p_mag > iit_pkg::MAG_LIM) begin
      p_mag = iit_pkg::MAG_LIM;
    end
    res = neg_r ? -$signed(p_mag) : $signed(p_mag);
  end

  // energy share: halve (backward Euler) or quarter (Crank-Nicolson), toward zero
  logic signed [63:0] res_part;
  always_comb begin
    if (scheme_r) begin
      res_part = (res + (res[63] ? 64'sd3 : 64'sd0)) >>> 2;
    end else begin
      res_part = (res + (res[63] ? 64'sd1 : 64'sd0)) >>> 1;
    end
  end

  logic signed [63:0] v_cn;
  always_comb begin
    v_cn = res - vp_x;
    if (v_cn > $signed(iit_pkg::MAG_LIM)) begin
      v_cn = $signed(iit_pkg::MAG_LIM);
    end else if (v_cn < -$signed(iit_pkg::MAG_LIM)) begin
      v_cn = -$signed(iit_pkg::MAG_LIM);
    end
  end

  // internal gradient term
  logic signed [32:0] gsum;
  logic signed [63:0] gi_term;
  always_comb begin
    gsum = {gi_r[31], gi_r} + {gpi_r[31], gpi_r};
    if (scheme_r && !static_r) begin
      gsum    = (gsum + (gsum[32] ? 33'sd1 : 33'sd0)) >>> 1;
      gi_term = {{31{gsum[32]}}, gsum};
    end else begin
      gi_term = {{32{gi_r[31]}}, gi_r};
    end
  end

  function automatic logic signed [63:0] sat_add(logic signed [63:0] x, logic signed [63:0] y);
    logic signed [63:0] s;
    s = x + y;
    if (x[63] == y[63] && s[63] != x[63]) begin
      s = x[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  logic signed [63:0] grad_cl, hess_cl;
  always_comb begin
    grad_cl = grad_r;
    if (grad_r > iit_pkg::GRAD_MAX) begin
      grad_cl = iit_pkg::GRAD_MAX;
    end else if (grad_r < iit_pkg::GRAD_MIN) begin
      grad_cl = iit_pkg::GRAD_MIN;
    end
    hess_cl = hess_r;
    if (hess_r > iit_pkg::GRAD_MAX) begin
      hess_cl = iit_pkg::GRAD_MAX;
    end else if (hess_r < 64'sd0) begin
      hess_cl = 64'sd0;
    end
  end

  logic step_end;
  assign step_end = (step_r == iit_pkg::ST_DE) || (static_r && step_r == iit_pkg::ST_MQG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r    <= 1'b0;
      static_r    <= 1'b0;
      dt_r        <= 31'd655;
      inv_r       <= 31'd6553600;
      alpha_r     <= 31'd0;
      gx_r        <= 32'sd0;
      gy_r        <= 32'sd0;
      gz_r        <= -32'sd642908;
      state_r     <= iit_pkg::S_IDLE;
      step_r      <= iit_pkg::ST_MG;
      axis_r      <= 2'd0;
      cnt_r       <= 3'd0;
      acc_e_r     <= 64'sd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (iit_pkg::cfg_reg_t'(cfg_ch.index))
          iit_pkg::REG_SCHEME:    scheme_r <= cfg_ch.data[0];
          iit_pkg::REG_STATIC:    static_r <= cfg_ch.data[0];
          iit_pkg::REG_STEP_TIME: dt_r     <= cfg_ch.data[30:0];
          iit_pkg::REG_INV_STEP:  inv_r    <= cfg_ch.data[30:0];
          iit_pkg::REG_ALPHA:     alpha_r  <= cfg_ch.data[30:0];
          iit_pkg::REG_GRAV_X:    gx_r     <= cfg_ch.data;
          iit_pkg::REG_GRAV_Y:    gy_r     <= cfg_ch.data;
          iit_pkg::REG_GRAV_Z:    gz_r     <= cfg_ch.data;
          default: ;
        endcase
      end

      // the output step reloads the register itself
      if (out_valid_r && out_ch.ready && state_r != iit_pkg::S_OUTP) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        iit_pkg::S_IDLE: begin
          if (in_fire) begin
            step_r  <= iit_pkg::ST_MG;
            state_r <= iit_pkg::S_LOAD;
          end
        end
        iit_pkg::S_LOAD: begin
          cnt_r   <= 3'd0;
          state_r <= iit_pkg::S_MUL;
        end
        iit_pkg::S_MUL: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd4) begin
            state_r <= iit_pkg::S_FIN;
          end
        end
        iit_pkg::S_FIN: begin
          if (step_end) begin
            state_r <= iit_pkg::S_ACC;
          end else begin
            step_r  <= iit_pkg::step_t'(step_r + 5'd1);
            state_r <= iit_pkg::S_LOAD;
          end
        end
        iit_pkg::S_ACC: begin
          acc_e_r <= sat_add(acc_e_r, energy_r);
          state_r <= iit_pkg::S_OUTP;
        end
        iit_pkg::S_OUTP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= iit_pkg::S_IDLE;
            if (last_r) begin
              acc_e_r <= 64'sd0;
              axis_r  <= 2'd0;
            end else if (32'(axis_r) + 32'd1 >= DIMENSIONS) begin
              axis_r <= 2'd0;
            end else begin
              axis_r <= axis_r + 2'd1;
            end
          end
        end
        default: state_r <= iit_pkg::S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_r    <= in_ch.position;
      qp_r   <= in_ch.prev_position;
      vp_r   <= in_ch.prev_velocity;
      m_r    <= in_ch.mass;
      gi_r   <= in_ch.internal_gradient;
      gpi_r  <= in_ch.prev_internal_gradient;
      ei_r   <= in_ch.internal_energy;
      last_r <= in_ch.last_element;
      g_r    <= (axis_r == 2'd0) ? gx_r : ((axis_r == 2'd1) ? gy_r : gz_r);
      hess_r <= 64'sd0;
    end

    if (state_r == iit_pkg::S_LOAD) begin
      mag_a_r <= op_a[63] ? 64'(-op_a) : 64'(op_a);
      mag_b_r <= op_b[63] ? 64'(-op_b) : 64'(op_b);
      neg_r   <= op_a[63] ^ op_b[63];
      prod_r  <= 128'd0;
    end

    if (state_r == iit_pkg::S_MUL) begin
      pp_r    <= limb_a * limb_b;
      sel_d_r <= cnt_r[1:0];
      if (cnt_r != 3'd0) begin
        prod_r <= prod_r + pp_shift;
      end
    end

    if (state_r == iit_pkg::S_FIN) begin
      case (step_r)
        iit_pkg::ST_MG:    grad_r   <= -res;
        iit_pkg::ST_MQG:   energy_r <= -res;
        iit_pkg::ST_VEL:   v_r      <= scheme_r ? v_cn : res;
        iit_pkg::ST_ACCEL: a_r      <= res;
        iit_pkg::ST_AM:    am_r     <= res;
        iit_pkg::ST_MA: begin
          ma_r   <= res;
          grad_r <= grad_r + res;
        end
        iit_pkg::ST_AMV:   grad_r   <= grad_r + res;
        iit_pkg::ST_MII:   hess_r   <= res;
        iit_pkg::ST_AMI:   hess_r   <= hess_r + res;
        iit_pkg::ST_KE,
        iit_pkg::ST_DE:    energy_r <= energy_r + res_part;
        iit_pkg::ST_DT2,
        iit_pkg::ST_MV,
        iit_pkg::ST_MVV:   tmp2_r   <= res;
        default:           tmp_r    <= res;
      endcase
    end

    if (state_r == iit_pkg::S_ACC) begin
      grad_r <= grad_r + gi_term;
      if (scheme_r && !static_r) begin
        hess_r <= hess_r <<< 1;
      end
    end

    if (state_r == iit_pkg::S_OUTP && out_free) begin
      out_grad_r   <= grad_cl[47:0];
      out_hess_r   <= hess_cl[46:0];
      out_end_r    <= last_r;
      out_energy_r <= last_r ? sat_add(acc_e_r, {{32{ei_r[31]}}, ei_r}) : 64'sd0;
    end
  end

  // the step counter never runs past the last product
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iit_pkg::S_FIN) |-> (step_r <= iit_pkg::ST_DE))
    else $error("sequencer step out of range");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(axis_r) < DIMENSIONS)
    else $error("axis counter out of range");

  // the run's energy sum clears once the last element's result is loaded
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iit_pkg::S_OUTP && out_free && last_r) |=> (acc_e_r == 64'sd0))
    else $error("energy sum not cleared at end of run");

endmodule

[dv/iit_checker.sv]
`timescale 1ns / 1ps

module iit_checker (
  input  logic        clk,
  input  logic        rst_n,
  iit_in_if           in_ch,
  iit_out_if          out_ch,
  iit_cfg_if          cfg_ch,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int FRAC = 16;
  localparam int DIMS = 3;
  localparam longint LIMV = 64'sh1000_0000_0000_0000;
  localparam longint GMAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint GMIN = -64'sh0000_8000_0000_0000;
  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [47:0] grad;
    logic        [46:0] hess;
    logic signed [63:0] energy;
    logic               run_end;
  } dof_result_t;

  dof_result_t result_q[$];

  logic        cn_mode, static_on;
  longint      step_dt, inv_dt, alpha;
  longint      grav[3];
  int          axis;
  longint      energy_acc;

  assign pending = result_q.size();

  // Magnitude product, truncated toward zero, clamped to 2^60
  function automatic longint fx_mul(longint a, longint b);
    logic neg;
    logic [63:0] ma, mb;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = ma * mb;
    if (p[127:64] != 0) p = LIMV;
    else p = p >> FRAC;
    if (p > LIMV) p = LIMV;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint add_sat(longint a, longint b);
    if (b > 0 && a > I64_MAX - b) return I64_MAX;
    if (b < 0 && a < I64_MIN - b) return I64_MIN;
    return a + b;
  endfunction

  task automatic predict_dof();
    longint q, qp, vp, m, gi, gpi, ei, g, grad, hess, en, d, v, a, am, ke, de;
    dof_result_t r;
    q = longint'(in_ch.position);
    qp = longint'(in_ch.prev_position);
    vp = longint'(in_ch.prev_velocity);
    m = longint'({1'b0, in_ch.mass});
    gi = longint'(in_ch.internal_gradient);
    gpi = longint'(in_ch.prev_internal_gradient);
    ei = longint'(in_ch.internal_energy);
    g = grav[axis];
    hess = 0;
    grad = -fx_mul(m, g);
    en = -fx_mul(fx_mul(m, q), g);
    if (static_on) begin
      grad += gi;
    end else begin
      d = q - qp;
      if (cn_mode) v = clamp(fx_mul(2 * d, inv_dt) - vp, -LIMV, LIMV);
      else v = fx_mul(d, inv_dt);
      a = fx_mul(v - vp, inv_dt);
      am = fx_mul(alpha, m);
      grad += fx_mul(m, a) + fx_mul(am, v);
      grad += cn_mode ? (gi + gpi) / 2 : gi;
      hess = fx_mul(fx_mul(m, inv_dt), inv_dt) + fx_mul(am, inv_dt);
      if (cn_mode) hess *= 2;
      ke = fx_mul(fx_mul(fx_mul(m, a), a), fx_mul(step_dt, step_dt));
      de = fx_mul(fx_mul(alpha, step_dt), fx_mul(fx_mul(m, v), v));
      en += cn_mode ? ke / 4 + de / 4 : ke / 2 + de / 2;
    end
    energy_acc = add_sat(energy_acc, en);
    r.grad = 48'(clamp(grad, GMIN, GMAX));
    r.hess = 47'(clamp(hess, 0, GMAX));
    if (in_ch.last_element) begin
      r.energy = add_sat(energy_acc, ei);
      r.run_end = 1'b1;
      energy_acc = 0;
      axis = 0;
    end else begin
      r.energy = 0;
      r.run_end = 1'b0;
      axis = (axis + 1 >= DIMS) ? 0 : axis + 1;
    end
    result_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cn_mode <= 1'b0;
      static_on <= 1'b0;
      step_dt <= 655;
      inv_dt <= 6553600;
      alpha <= 0;
      grav[0] <= 0;
      grav[1] <= 0;
      grav[2] <= -642908;
      axis <= 0;
      energy_acc <= 0;
      fail_count <= 0;
      result_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (iit_pkg::cfg_reg_t'(cfg_ch.index))
          iit_pkg::REG_SCHEME:    cn_mode = cfg_ch.data[0];
          iit_pkg::REG_STATIC:    static_on = cfg_ch.data[0];
          iit_pkg::REG_STEP_TIME: step_dt = {33'd0, cfg_ch.data[30:0]};
          iit_pkg::REG_INV_STEP:  inv_dt = {33'd0, cfg_ch.data[30:0]};
          iit_pkg::REG_ALPHA:     alpha = {33'd0, cfg_ch.data[30:0]};
          iit_pkg::REG_GRAV_X:    grav[0] = longint'(signed'(cfg_ch.data));
          iit_pkg::REG_GRAV_Y:    grav[1] = longint'(signed'(cfg_ch.data));
          iit_pkg::REG_GRAV_Z:    grav[2] = longint'(signed'(cfg_ch.data));
          default: ;
        endcase
      end
      // compare before predicting so a same-edge input cannot satisfy its own output
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          automatic dof_result_t e = result_q.pop_front();
          automatic int bad = 0;
          if (out_ch.total_gradient !== e.grad) begin
            $error("total_gradient exp %0d got %0d", e.grad, out_ch.total_gradient);
            bad++;
          end
          if (out_ch.inertial_hessian_diag !== e.hess) begin
            $error("inertial_hessian_diag exp %0d got %0d", e.hess,
                   out_ch.inertial_hessian_diag);
            bad++;
          end
          if (out_ch.total_energy !== e.energy) begin
            $error("total_energy exp %0d got %0d", e.energy, out_ch.total_energy);
            bad++;
          end
          if (out_ch.run_end !== e.run_end) begin
            $error("run_end exp %0d got %0d", e.run_end, out_ch.run_end);
            bad++;
          end
          fail_count <= fail_count + bad;
        end
      end
      if (in_ch.valid && in_ch.ready) predict_dof();
    end
  end
endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned fail_count, pending;
  int unsigned rx_pattern = 0;
  int unsigned out_cycle = 0;

  iit_in_if  in_ch();
  iit_out_if out_ch();
  iit_cfg_if cfg_ch();

  implicit_integrator_inertia_terms_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  iit_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stall pattern: mode changes every so often, sometimes always ready
  always @(posedge clk) begin
    out_cycle <= out_cycle + 1;
    if (out_cycle % 512 == 0) rx_pattern <= $urandom_range(0, 3);
    case (rx_pattern)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= (out_cycle % 7) < 3;
      default: out_ch.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 20)) - 10) << 16;
      3: return $urandom;
      default: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    endcase
  endfunction

  // hold valid across back-to-back writes; the caller drops it
  task automatic write_reg(iit_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  task automatic send_dof(logic [31:0] q, logic [31:0] qp, logic [31:0] vp,
                          logic [30:0] m, logic [31:0] gi, logic [31:0] gpi,
                          logic [31:0] ei, logic last);
    in_ch.valid <= 1'b1;
    in_ch.position <= q;
    in_ch.prev_position <= qp;
    in_ch.prev_velocity <= vp;
    in_ch.mass <= m;
    in_ch.internal_gradient <= gi;
    in_ch.prev_internal_gradient <= gpi;
    in_ch.internal_energy <= ei;
    in_ch.last_element <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random(int n);
    int burst;
    int run_left;
    int gap;
    burst = 0;
    run_left = $urandom_range(1, 7);
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(1, 20));
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 12);
      end
      burst--;
      run_left--;
      send_dof(pick32(), pick32(), pick32(), 31'(pick32()), $urandom,
               pick32(), $urandom, run_left == 0 || i == n - 1);
      if (run_left == 0) run_left = $urandom_range(1, 7);
    end
    in_ch.valid <= 1'b0;
  endtask

  // register settings per phase: scheme, static, dt, 1/dt, alpha, gx, gy, gz
  task automatic configure(int ph);
    logic [31:0] dt;
    case (ph)
      0: dt = 32'd0;
      1: dt = 32'h7FFF_FFFF;
      2: dt = 32'd655;
      default: dt = $urandom_range(1, 32'h0002_0000);
    endcase
    write_reg(iit_pkg::REG_SCHEME, 32'(ph % 2));
    write_reg(iit_pkg::REG_STATIC, 32'(ph == 4));
    write_reg(iit_pkg::REG_STEP_TIME, dt);
    write_reg(iit_pkg::REG_INV_STEP, ph == 1 ? 32'd0 : (ph == 0 ? 32'h7FFF_FFFF :
                                     $urandom_range(1, 32'h0100_0000)));
    write_reg(iit_pkg::REG_ALPHA, ph == 1 ? 32'h7FFF_FFFF :
                                  (ph == 0 ? 32'd0 : $urandom_range(0, 32'h2_0000)));
    write_reg(iit_pkg::REG_GRAV_X, ph == 1 ? 32'h8000_0000 : pick32());
    write_reg(iit_pkg::REG_GRAV_Y, ph == 1 ? 32'h7FFF_FFFF : pick32());
    write_reg(iit_pkg::REG_GRAV_Z, pick32());
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.position <= '0;
    in_ch.prev_position <= '0;
    in_ch.prev_velocity <= '0;
    in_ch.mass <= '0;
    in_ch.internal_gradient <= '0;
    in_ch.prev_internal_gradient <= '0;
    in_ch.internal_energy <= '0;
    in_ch.last_element <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: reset settings and extremes
    send_dof(32'h0001_0000, 32'h0, 32'h0, 31'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b0);
    send_dof(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b0);
    send_dof(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_dof(32'h0, 32'h0, 32'h0, 31'h0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 1'b1);
    for (int i = 0; i < 5; i++)
      send_dof(32'hFFFF_0000, 32'h1_0000, 32'h2_0000, 31'h4_0000, 32'hFFFF_FFFF,
               32'h1, 32'hFFFF_FFFF, i == 4);
    in_ch.valid <= 1'b0;
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      configure(ph);
      send_random(ph == 5 ? 1450 : 100);
      // hold off until every result is back
      drain();
    end
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
